FILE: rtl/ccfd_pkg.sv
// -----------------------------------------------------------------------------
// ccfd_pkg
// Shared types, constants and the CRC byte update for the COBS frame decoder.
// -----------------------------------------------------------------------------
package ccfd_pkg;

   // Default width of the decoded byte counter.
   localparam int COUNT_WIDTH = 16;

   // Default depths of the queue behind the front end and of the result queue.
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // Configuration register indexes.
   localparam int                 CSR_INDEX_WIDTH = 2;
   localparam logic [1:0]         REG_MAX_LENGTH  = 2'd0;
   localparam logic [1:0]         REG_CRC_POLY    = 2'd1;
   localparam logic [1:0]         REG_CRC_INIT    = 2'd2;

   // Configuration reset values.
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;
   localparam logic [15:0] CRC_POLY_RESET   = 16'h1021;
   localparam logic [15:0] CRC_INIT_RESET   = 16'hFFFF;

   // A code byte of this value opens a block that is not followed by a zero.
   localparam logic [7:0] RUN_CODE_FULL = 8'hFF;

   // Work items passed from the front end to the back end.
   typedef enum logic [1:0] {
      CMD_PUSH,
      CMD_END,
      CMD_OVF
   } cmd_kind_type;

   // Status codes carried on status records.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CRC_ERR  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } frame_status_type;

   // One decoded work item.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;      // decoded byte for CMD_PUSH
      logic         emit;      // the delay line is full, the oldest byte leaves
      logic         short_frm; // fewer than two decoded bytes at the delimiter
      logic [15:0]  length;    // payload length for status records
      logic [15:0]  crc_seed;  // CRC start value latched when the frame restarted
   } cmd_type;

   // One result record.
   typedef struct packed {
      logic             is_status;
      logic [7:0]       payload_byte;
      frame_status_type frame_status;
      logic [15:0]      payload_length;
   } rsp_type;

   // MSB-first CRC-16 update over one byte.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                            input logic [7:0]  data,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/ccfd_queue.sv
// -----------------------------------------------------------------------------
// ccfd_queue
// Small first-in first-out queue built from registers, head shown directly.
// -----------------------------------------------------------------------------
module ccfd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Storage is written without reset; only the pointers and the fill count need it.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

FILE: rtl/ccfd_front.sv
// -----------------------------------------------------------------------------
// ccfd_front
// COBS decode front end: tracks code blocks, counts decoded bytes and turns
// received bytes into decoded-byte, end-of-frame or overflow items.
// -----------------------------------------------------------------------------
module ccfd_front #(
   parameter int COUNT_WIDTH = ccfd_pkg::COUNT_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [7:0]        req_rx_byte,
   input  logic              cmd_full,
   input  logic [15:0]       max_length,
   input  logic [15:0]       crc_init,
   output logic              cmd_push,
   output ccfd_pkg::cmd_type cmd_data
);

   localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   logic                   in_run_ff, in_run_in;
   logic [7:0]             block_left_ff, block_left_in;
   logic [7:0]             last_code_ff, last_code_in;
   logic                   block_seen_ff, block_seen_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   restart_ff, restart_in;
   logic [15:0]            seed_ff, seed_in;

   logic                   accept;
   logic [LW-1:0]          count_ext;
   logic [LW-1:0]          len_ext;
   logic                   short_frm;
   logic                   at_limit;
   logic [15:0]            seed_now;

   assign accept    = req_push && !cmd_full;
   assign count_ext = LW'(count_ff);
   assign short_frm = (count_ext < LW'(2));
   assign len_ext   = short_frm ? '0 : count_ext - LW'(2);

   // The limit is max_length, capped at the largest count the counter holds.
   assign at_limit  = (count_ext >= LW'(max_length)) || (count_ff == '1);

   // After a status the CRC start value is taken from the register at the
   // next byte; otherwise the frame keeps the value latched at its restart.
   assign seed_now  = restart_ff ? crc_init : seed_ff;

   // Classify the byte and compute the next decoder state.
   always_comb begin
      in_run_in          = in_run_ff;
      block_left_in      = block_left_ff;
      last_code_in       = last_code_ff;
      block_seen_in      = block_seen_ff;
      count_in           = count_ff;
      restart_in         = restart_ff;
      seed_in            = seed_ff;
      cmd_push           = 1'b0;
      cmd_data.kind      = ccfd_pkg::CMD_PUSH;
      cmd_data.data      = req_rx_byte;
      cmd_data.emit      = !short_frm;
      cmd_data.short_frm = short_frm;
      cmd_data.length    = len_ext[15:0];
      cmd_data.crc_seed  = seed_now;

      if (accept) begin
         restart_in = 1'b0;
         seed_in    = seed_now;
         priority if (req_rx_byte == 8'h00) begin
            // Delimiter: report a non-empty frame, then start over.
            if (count_ff != '0) begin
               cmd_push      = 1'b1;
               cmd_data.kind = ccfd_pkg::CMD_END;
               restart_in    = 1'b1;
            end else begin
               seed_in       = crc_init;
            end
            in_run_in     = 1'b0;
            block_left_in = 8'h00;
            last_code_in  = ccfd_pkg::RUN_CODE_FULL;
            block_seen_in = 1'b0;
            count_in      = '0;
         end else if (at_limit) begin
            // Frame grew too long.
            cmd_push      = 1'b1;
            cmd_data.kind = ccfd_pkg::CMD_OVF;
            restart_in    = 1'b1;
            in_run_in     = 1'b0;
            block_left_in = 8'h00;
            last_code_in  = ccfd_pkg::RUN_CODE_FULL;
            block_seen_in = 1'b0;
            count_in      = '0;
         end else if (!in_run_ff) begin
            // Code byte: insert a zero unless the previous block was a full run.
            if (block_seen_ff && (last_code_ff != ccfd_pkg::RUN_CODE_FULL)) begin
               cmd_push      = 1'b1;
               cmd_data.data = 8'h00;
               count_in      = count_ff + COUNT_WIDTH'(1);
            end
            block_seen_in = 1'b1;
            last_code_in  = req_rx_byte;
            block_left_in = req_rx_byte;
            in_run_in     = (req_rx_byte != 8'h01);
         end else begin
            // Run data byte.
            cmd_push      = 1'b1;
            count_in      = count_ff + COUNT_WIDTH'(1);
            block_left_in = block_left_ff - 8'd1;
            if (block_left_ff == 8'd2) begin
               in_run_in = 1'b0;
            end
         end
      end
   end

   // Decoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff     <= 1'b0;
         block_left_ff <= 8'h00;
         last_code_ff  <= ccfd_pkg::RUN_CODE_FULL;
         block_seen_ff <= 1'b0;
         count_ff      <= '0;
         restart_ff    <= 1'b0;
         seed_ff       <= ccfd_pkg::CRC_INIT_RESET;
      end else begin
         in_run_ff     <= in_run_in;
         block_left_ff <= block_left_in;
         last_code_ff  <= last_code_in;
         block_seen_ff <= block_seen_in;
         count_ff      <= count_in;
         restart_ff    <= restart_in;
         seed_ff       <= seed_in;
      end
   end

endmodule

FILE: rtl/ccfd_back.sv
// -----------------------------------------------------------------------------
// ccfd_back
// Back end: two-byte delay line, CRC-16 over the bytes leaving it, and the
// end-of-frame check against the two held CRC bytes.
// -----------------------------------------------------------------------------
module ccfd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  ccfd_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output ccfd_pkg::rsp_type rsp_data,
   input  logic [15:0]       crc_poly
);

   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [15:0] crc_ff, crc_in;
   logic        fresh_ff, fresh_in;
   logic [15:0] crc_eff;

   // A fresh frame starts from the value the front end latched at its restart.
   assign crc_eff = fresh_ff ? cmd_data.crc_seed : crc_ff;
   assign cmd_pop = !cmd_empty && !rsp_full;

   // Execute one work item.
   always_comb begin
      held0_in                = held0_ff;
      held1_in                = held1_ff;
      crc_in                  = crc_ff;
      fresh_in                = fresh_ff;
      rsp_push                = 1'b0;
      rsp_data.is_status      = 1'b0;
      rsp_data.payload_byte   = 8'h00;
      rsp_data.frame_status   = ccfd_pkg::STATUS_OK;
      rsp_data.payload_length = 16'h0000;

      if (cmd_pop) begin
         unique case (cmd_data.kind)
            ccfd_pkg::CMD_PUSH: begin
               if (cmd_data.emit) begin
                  rsp_push              = 1'b1;
                  rsp_data.payload_byte = held0_ff;
                  crc_in                = ccfd_pkg::crc_feed(crc_eff, held0_ff, crc_poly);
                  fresh_in              = 1'b0;
               end
               held0_in = held1_ff;
               held1_in = cmd_data.data;
            end
            ccfd_pkg::CMD_END: begin
               rsp_push                = 1'b1;
               rsp_data.is_status      = 1'b1;
               rsp_data.payload_length = cmd_data.length;
               if (cmd_data.short_frm || ({held0_ff, held1_ff} != crc_eff)) begin
                  rsp_data.frame_status = ccfd_pkg::STATUS_CRC_ERR;
               end
               fresh_in = 1'b1;
            end
            ccfd_pkg::CMD_OVF: begin
               rsp_push                = 1'b1;
               rsp_data.is_status      = 1'b1;
               rsp_data.frame_status   = ccfd_pkg::STATUS_OVERFLOW;
               rsp_data.payload_length = cmd_data.length;
               fresh_in                = 1'b1;
            end
            default: begin
               fresh_in = fresh_ff;
            end
         endcase
      end
   end

   // Delay line and CRC register carry no reset; the fresh flag marks them.
   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      crc_ff   <= crc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
      end else begin
         fresh_ff <= fresh_in;
      end
   end

   // A status record always leaves the next frame with a fresh CRC.
   assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && (cmd_data.kind != ccfd_pkg::CMD_PUSH)) |=> fresh_ff)
      else $error("CRC not marked fresh after a status record");

   // An emitted data byte has been folded into the running CRC.
   assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && (cmd_data.kind == ccfd_pkg::CMD_PUSH) && cmd_data.emit) |=> !fresh_ff)
      else $error("CRC still fresh after a data byte was emitted");

   // A result is only produced while a work item is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (cmd_pop && !rsp_full))
      else $error("Result produced without a work item");

endmodule

FILE: rtl/cobs_crc_frame_decoder_core.sv
// -----------------------------------------------------------------------------
// cobs_crc_frame_decoder_core
// COBS frame decoder with CRC-16 check, one received byte per transaction.
// -----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  req_      in         push / full            rx_byte
//  rsp_      out        pop / empty            is_status, payload_byte,
//                                              frame_status, payload_length
//  csr_      in         valid / ready          index, data
//
//  One byte is taken every cycle while req_full is low; the COBS step in the
//  front end and the byte-wide CRC update in the back end are each combinational.
//  A result passes the work-item queue and the result queue, both registered,
//  before it can be popped.
//  Reset is synchronous and active high; configuration returns to its
//  defaults and no clearing pass is needed afterwards.
//  With pop held low, full rises once two results and two work items wait.
// -----------------------------------------------------------------------------
module cobs_crc_frame_decoder_core #(
   parameter int COUNT_WIDTH = ccfd_pkg::COUNT_WIDTH,
   parameter int CMD_DEPTH   = ccfd_pkg::CMD_DEPTH,
   parameter int RSP_DEPTH   = ccfd_pkg::RSP_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_is_status,
   output logic [7:0]                           rsp_payload_byte,
   output logic [1:0]                           rsp_frame_status,
   output logic [15:0]                          rsp_payload_length,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ccfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                          csr_data
);

   localparam int CMD_W = $bits(ccfd_pkg::cmd_type);
   localparam int RSP_W = $bits(ccfd_pkg::rsp_type);

   logic [15:0]       max_length_ff;
   logic [15:0]       crc_poly_ff;
   logic [15:0]       crc_init_ff;

   logic              cmd_push;
   logic              cmd_full;
   logic              cmd_empty;
   logic              cmd_pop;
   ccfd_pkg::cmd_type front_cmd;
   ccfd_pkg::cmd_type back_cmd;
   logic [CMD_W-1:0]  back_cmd_vec;

   logic              back_push;
   logic              rsp_full;
   ccfd_pkg::rsp_type back_rsp;
   ccfd_pkg::rsp_type head_rsp;
   logic [RSP_W-1:0]  head_rsp_vec;

   // Configuration registers, always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= ccfd_pkg::MAX_LENGTH_RESET;
         crc_poly_ff   <= ccfd_pkg::CRC_POLY_RESET;
         crc_init_ff   <= ccfd_pkg::CRC_INIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ccfd_pkg::REG_MAX_LENGTH: max_length_ff <= csr_data;
            ccfd_pkg::REG_CRC_POLY:   crc_poly_ff   <= csr_data;
            ccfd_pkg::REG_CRC_INIT:   crc_init_ff   <= csr_data;
            default:                  max_length_ff <= max_length_ff;
         endcase
      end
   end

   // Front end: COBS decoding and frame length tracking.
   ccfd_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .cmd_full    (cmd_full),
      .max_length  (max_length_ff),
      .crc_init    (crc_init_ff),
      .cmd_push    (cmd_push),
      .cmd_data    (front_cmd)
   );

   assign req_full = cmd_full;

   // Queue between front and back end.
   ccfd_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd_vec),
      .empty     (cmd_empty)
   );

   assign back_cmd = ccfd_pkg::cmd_type'(back_cmd_vec);

   // Back end: delay line, CRC and status.
   ccfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (back_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (back_push),
      .rsp_data  (back_rsp),
      .crc_poly  (crc_poly_ff)
   );

   // Result queue.
   ccfd_queue #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (head_rsp_vec),
      .empty     (rsp_empty)
   );

   assign head_rsp           = ccfd_pkg::rsp_type'(head_rsp_vec);
   assign rsp_is_status      = head_rsp.is_status;
   assign rsp_payload_byte   = head_rsp.payload_byte;
   assign rsp_frame_status   = head_rsp.frame_status;
   assign rsp_payload_length = head_rsp.payload_length;

endmodule
